// ----- src/mtf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants, codes and types of the move-to-front keyed table.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 32;
  localparam int PRICE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PRICE_W-1:0]      price;
    logic                    avail;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- src/move_to_front_keyed_table.sv -----
// ----------------------------------------------------------------------------
// move_to_front_keyed_table
// Insert, search and delete scan the stored keys, one key compare per cycle;
// search and delete then shift entries through the memory's write port, and
// the result is registered.
// List emits one entry per cycle from the registered read port; busy is high
// throughout. Results cannot be stalled. Reset empties the table.
// ----------------------------------------------------------------------------
module move_to_front_keyed_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mtf_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [mtf_pkg::KEY_W-1:0]    item_key_i,
  input  logic [mtf_pkg::PRICE_W-1:0]         price_cents_i,
  input  logic                                available_in_i,
  output logic                                done_o,
  output logic [mtf_pkg::STATUS_W-1:0]        status_o,
  output logic signed [mtf_pkg::KEY_W-1:0]    found_key_o,
  output logic [mtf_pkg::PRICE_W-1:0]         found_price_o,
  output logic                                found_available_o,
  output logic [mtf_pkg::COUNT_W-1:0]         entry_count_o,
  output logic                                last_result_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  localparam int CW = mtf_pkg::CNT_W;
  localparam int IW = mtf_pkg::IDX_W;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rvld_q, rvld_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          wpend_q, wpend_d;
  logic [IW-1:0] waddr_q, waddr_d;
  logic [CW-1:0] count_q, count_d;

  logic [mtf_pkg::FUNC_W-1:0] func_q;
  mtf_pkg::entry_t            new_q;
  mtf_pkg::entry_t            entry_q, entry_d;

  mtf_pkg::mem_req_t mem_req;
  mtf_pkg::entry_t   rdata;

  logic                         accept;
  logic                         hit;
  logic [CW-1:0]                ptr_m1;
  logic [CW-1:0]                idx_m1;
  logic                         emit;
  logic [mtf_pkg::STATUS_W-1:0] em_status;
  mtf_pkg::entry_t              em_entry;
  logic                         em_last;

  logic                         done_q;
  logic [mtf_pkg::STATUS_W-1:0] status_q;
  mtf_pkg::entry_t              out_entry_q;
  logic [mtf_pkg::COUNT_W-1:0]  out_count_q;
  logic                         last_q;

  mtf_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign hit    = rvld_q && (rdata.key == new_q.key);
  assign ptr_m1 = ptr_q - CW'(1);
  assign idx_m1 = idx_q - CW'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rvld_d   = rvld_q;
    ptr_d    = ptr_q;
    wpend_d  = 1'b0;
    waddr_d  = waddr_q;
    count_d  = count_q;
    entry_d  = entry_q;

    mem_req.we    = 1'b0;
    mem_req.waddr = waddr_q;
    mem_req.wdata = rdata;
    mem_req.raddr = idx_q[IW-1:0];

    emit      = 1'b0;
    em_status = mtf_pkg::STAT_OK;
    em_entry  = '0;
    em_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          rvld_d = 1'b0;
          if ((func_i != mtf_pkg::FUNC_INSERT) && (count_q == '0)) begin
            emit      = 1'b1;
            em_status = mtf_pkg::STAT_EMPTY;
          end else if (func_i == mtf_pkg::FUNC_LIST) begin
            state_d = S_LIST;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          entry_d = rdata;
          case (func_q)
            mtf_pkg::FUNC_INSERT: begin
              emit      = 1'b1;
              em_status = mtf_pkg::STAT_DUP;
              em_entry  = rdata;
              state_d   = S_IDLE;
            end
            mtf_pkg::FUNC_SEARCH: begin
              ptr_d   = idx_m1;
              state_d = S_MOVE;
            end
            mtf_pkg::FUNC_DELETE: begin
              ptr_d   = idx_q;
              state_d = S_MOVE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else if (idx_q == count_q) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (func_q == mtf_pkg::FUNC_INSERT) begin
            if (count_q == CW'(mtf_pkg::TABLE_DEPTH)) begin
              em_status = mtf_pkg::STAT_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_q[IW-1:0];
              mem_req.wdata = new_q;
              count_d       = count_q + CW'(1);
              em_entry      = new_q;
            end
          end else begin
            em_status = mtf_pkg::STAT_NOTFOUND;
          end
        end else begin
          idx_d  = idx_q + CW'(1);
          rvld_d = 1'b1;
        end
      end

      S_MOVE: begin
        if (wpend_q) begin
          mem_req.we = 1'b1;
        end
        if (func_q == mtf_pkg::FUNC_SEARCH) begin
          if (ptr_q != '0) begin
            mem_req.raddr = ptr_m1[IW-1:0];
            waddr_d       = ptr_q[IW-1:0];
            wpend_d       = 1'b1;
            ptr_d         = ptr_m1;
          end else if (!wpend_q) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = entry_q;
            emit          = 1'b1;
            em_entry      = entry_q;
            state_d       = S_IDLE;
          end
        end else begin
          if (ptr_q != count_q) begin
            mem_req.raddr = ptr_q[IW-1:0];
            waddr_d       = ptr_m1[IW-1:0];
            wpend_d       = 1'b1;
            ptr_d         = ptr_q + CW'(1);
          end else if (!wpend_q) begin
            count_d  = count_q - CW'(1);
            emit     = 1'b1;
            em_entry = entry_q;
            state_d  = S_IDLE;
          end
        end
      end

      S_LIST: begin
        if (rvld_q) begin
          emit     = 1'b1;
          em_entry = rdata;
          em_last  = (idx_q == count_q);
        end
        if (idx_q != count_q) begin
          idx_d  = idx_q + CW'(1);
          rvld_d = 1'b1;
        end else begin
          rvld_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      rvld_q  <= 1'b0;
      ptr_q   <= '0;
      wpend_q <= 1'b0;
      waddr_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rvld_q  <= rvld_d;
      ptr_q   <= ptr_d;
      wpend_q <= wpend_d;
      waddr_q <= waddr_d;
      count_q <= count_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (accept) begin
      func_q      <= func_i;
      new_q.key   <= item_key_i;
      new_q.price <= price_cents_i;
      new_q.avail <= available_in_i;
    end
    if (emit) begin
      status_q    <= em_status;
      out_entry_q <= em_entry;
      out_count_q <= mtf_pkg::COUNT_W'(count_d);
      last_q      <= em_last;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign found_key_o       = out_entry_q.key;
  assign found_price_o     = out_entry_q.price;
  assign found_available_o = out_entry_q.avail;
  assign entry_count_o     = out_count_q;
  assign last_result_o     = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(mtf_pkg::TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_partial_from_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_result_o) |-> ($past(state_q) == S_LIST))
    else $error("A non-final result beat appeared outside a list.");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q != S_IDLE))
    else $error("Memory written while idle.");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("Accepted command produced neither work nor a result.");
`endif

endmodule

// ----- src/mtf_store.sv -----
// ----------------------------------------------------------------------------
// mtf_store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtf_store (
  input  logic              clk_i,
  input  mtf_pkg::mem_req_t req_i,
  output mtf_pkg::entry_t   rdata_o
);

  mtf_pkg::entry_t mem_q [mtf_pkg::TABLE_DEPTH];
  mtf_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/tb_move_to_front_keyed_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_move_to_front_keyed_table
// Drives insert, search, delete and list commands into the keyed table and
// checks every result beat against a shadow copy of the table that is updated
// when each command is accepted. A directed opening covers the empty,
// duplicate, miss and move-to-front cases; random commands then alternate
// between growing and shrinking the table under random sender gaps.
// ----------------------------------------------------------------------------
module tb_move_to_front_keyed_table;
  import mtf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CMDS = 156;
  localparam int POOL_SIZE   = 20;

  typedef struct {
    logic [FUNC_W-1:0] func;
    entry_t            data;
    bit                drain_first;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    entry_t              hit;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } reply_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [FUNC_W-1:0]         func_i = FUNC_INSERT;
  logic signed [KEY_W-1:0]   item_key_i = '0;
  logic [PRICE_W-1:0]        price_cents_i = '0;
  logic                      available_in_i = 1'b0;
  logic                      done_o;
  logic [STATUS_W-1:0]       status_o;
  logic signed [KEY_W-1:0]   found_key_o;
  logic [PRICE_W-1:0]        found_price_o;
  logic                      found_available_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      last_result_o;

  command_t command_q[$];
  command_t cur_cmd;
  reply_t   pending_replies[$];
  entry_t   shadow_table[TABLE_DEPTH];
  int       shadow_used = 0;
  int       total_cmds = 0;
  int       n_accepted = 0;
  int       n_finished = 0;
  int       idle_pct = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  move_to_front_keyed_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .item_key_i        (item_key_i),
    .price_cents_i     (price_cents_i),
    .available_in_i    (available_in_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .found_key_o       (found_key_o),
    .found_price_o     (found_price_o),
    .found_available_o (found_available_o),
    .entry_count_o     (entry_count_o),
    .last_result_o     (last_result_o)
  );

  initial forever #2 clk_i = ~clk_i;

  function automatic void queue_cmd(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                    logic [PRICE_W-1:0] p, logic a, bit hold);
    command_t c;
    c.func = f;
    c.data.key = k;
    c.data.price = p;
    c.data.avail = a;
    c.drain_first = hold;
    command_q.push_back(c);
  endfunction

  function automatic void expect_reply(logic [STATUS_W-1:0] st, entry_t e, logic last);
    reply_t r;
    r.status = st;
    r.hit = e;
    r.count = COUNT_W'(shadow_used);
    r.last = last;
    pending_replies.push_back(r);
  endfunction

  function automatic void predict_table_op(command_t c);
    int     hit;
    entry_t e;
    entry_t none;
    hit = -1;
    none = '0;
    for (int i = 0; i < shadow_used; i++) begin
      if (hit < 0 && shadow_table[i].key == c.data.key) hit = i;
    end
    if (c.func == FUNC_INSERT) begin
      if (hit >= 0) begin
        expect_reply(STAT_DUP, shadow_table[hit], 1'b1);
      end else if (shadow_used >= TABLE_DEPTH) begin
        expect_reply(STAT_FULL, none, 1'b1);
      end else begin
        shadow_table[shadow_used] = c.data;
        shadow_used++;
        expect_reply(STAT_OK, c.data, 1'b1);
      end
    end else if (shadow_used == 0) begin
      expect_reply(STAT_EMPTY, none, 1'b1);
    end else if (c.func == FUNC_LIST) begin
      for (int i = 0; i < shadow_used; i++) begin
        expect_reply(STAT_OK, shadow_table[i], i == shadow_used - 1);
      end
    end else if (hit < 0) begin
      expect_reply(STAT_NOTFOUND, none, 1'b1);
    end else if (c.func == FUNC_SEARCH) begin
      e = shadow_table[hit];
      for (int i = hit; i > 0; i--) shadow_table[i] = shadow_table[i-1];
      shadow_table[0] = e;
      expect_reply(STAT_OK, e, 1'b1);
    end else begin
      e = shadow_table[hit];
      for (int i = hit; i < shadow_used - 1; i++) shadow_table[i] = shadow_table[i+1];
      shadow_used--;
      expect_reply(STAT_OK, e, 1'b1);
    end
  endfunction

  // Driver: a command stays on the ports until the table accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= FUNC_INSERT;
      item_key_i <= '0;
      price_cents_i <= '0;
      available_in_i <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_table_op(cur_cmd);
        n_accepted++;
      end
      if (n_accepted < total_cmds / 3) idle_pct = 37;
      else if (n_accepted < 2 * total_cmds / 3) idle_pct = 48;
      else idle_pct = 0;
      if (!(start && busy)) begin
        if (command_q.size() != 0 && $urandom_range(99) >= idle_pct &&
            (!command_q[0].drain_first || n_accepted == n_finished)) begin
          cur_cmd = command_q.pop_front();
          start <= 1'b1;
          func_i <= cur_cmd.func;
          item_key_i <= cur_cmd.data.key;
          price_cents_i <= cur_cmd.data.price;
          available_in_i <= cur_cmd.data.avail;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    reply_t r;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: status %0d key %0d count %0d",
                   status_o, found_key_o, entry_count_o);
        mismatches++;
      end else begin
        r = pending_replies.pop_front();
        if (r.last) n_finished <= n_finished + 1;
        if (status_o !== r.status || found_key_o !== r.hit.key ||
            found_price_o !== r.hit.price || found_available_o !== r.hit.avail ||
            entry_count_o !== r.count || last_result_o !== r.last) begin
          if (mismatches < 10) begin
            $display("mismatch: expected status %0d key %0d price %0h avail %0b count %0d last %0b",
                     r.status, r.hit.key, r.hit.price, r.hit.avail, r.count, r.last);
            $display("          got status %0d key %0d price %0h avail %0b count %0d last %0b",
                     status_o, found_key_o, found_price_o, found_available_o,
                     entry_count_o, last_result_o);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_move_to_front_keyed_table: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    logic signed [KEY_W-1:0] k;
    logic [PRICE_W-1:0]      p;
    logic [FUNC_W-1:0]       f;
    int                      pick;
    bit                      grow;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = '0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    queue_cmd(FUNC_SEARCH, 32'sd5, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, 32'sd5, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_LIST, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_INSERT, 32'sh8000_0000, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_INSERT, 32'sh7FFF_FFFF, '1, 1'b1, 1'b0);
    queue_cmd(FUNC_INSERT, 32'sh7FFF_FFFF, 32'd123, 1'b0, 1'b0);
    queue_cmd(FUNC_INSERT, '0, 32'h8000_0000, 1'b1, 1'b0);
    queue_cmd(FUNC_INSERT, -1, 32'd1, 1'b0, 1'b0);
    queue_cmd(FUNC_LIST, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_SEARCH, 32'sh7FFF_FFFF, '0, 1'b0, 1'b1);
    queue_cmd(FUNC_LIST, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_SEARCH, 32'sh7FFF_FFFF, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_SEARCH, -1, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_SEARCH, 32'sd12345, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, 32'sd777, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_LIST, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, 32'sh8000_0000, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, -1, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_DELETE, 32'sh7FFF_FFFF, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_LIST, '0, '0, 1'b0, 1'b0);
    queue_cmd(FUNC_INSERT, 32'sh5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, 1'b0);
    queue_cmd(FUNC_INSERT, 32'shA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0);
    queue_cmd(FUNC_SEARCH, 32'shA5A5_A5A5, '0, 1'b0, 1'b0);

    // Random commands alternate between blocks that fill the table and
    // blocks that drain it, so both the full and the empty table recur.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      grow = ((n / 30) % 2) == 0;
      pick = $urandom_range(99);
      if (grow) begin
        if (pick < 70) f = FUNC_INSERT;
        else if (pick < 82) f = FUNC_SEARCH;
        else if (pick < 91) f = FUNC_DELETE;
        else f = FUNC_LIST;
      end else begin
        if (pick < 15) f = FUNC_INSERT;
        else if (pick < 40) f = FUNC_SEARCH;
        else if (pick < 90) f = FUNC_DELETE;
        else f = FUNC_LIST;
      end
      if ($urandom_range(99) < 20) k = $urandom;
      else k = key_pool[$urandom_range(POOL_SIZE - 1)];
      case ($urandom_range(9))
        0: p = '0;
        1: p = '1;
        default: p = $urandom;
      endcase
      queue_cmd(f, k, p, 1'($urandom_range(1)), (n % 60) == 0);
    end
    total_cmds = command_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || start || pending_replies.size() != 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb_move_to_front_keyed_table: done, clean");
    end else begin
      $display("tb_move_to_front_keyed_table: done, errors");
    end
    $finish;
  end

endmodule
